### rtl/gocd_pkg.sv
package gocd_pkg;

  localparam int unsigned CAL_SAMPLES_LOG2 = 7;
  localparam int unsigned RATE_W = 16;
  // Accumulator wide enough that 2^N full-scale samples never wrap.
  localparam int unsigned SUM_W = RATE_W + CAL_SAMPLES_LOG2;
  localparam int unsigned CNT_W = CAL_SAMPLES_LOG2 + 1;
  localparam int unsigned PEAK_W = RATE_W - 1;
  localparam logic [CNT_W-1:0] CAL_SAMPLES = CNT_W'(1) << CAL_SAMPLES_LOG2;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef logic signed [RATE_W-1:0] rate_t;

  typedef struct packed {
    logic  operation;
    rate_t rate_x;
    rate_t rate_y;
    rate_t rate_z;
  } in_req_t;

  typedef struct packed {
    rate_t out_x;
    rate_t out_y;
    rate_t out_z;
  } out_res_t;

  typedef struct packed {
    logic clear;
    logic accum;
    logic load;
  } lane_ctl_t;

endpackage

### rtl/gocd_lane.sv
module gocd_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gocd_pkg::lane_ctl_t ctl_i,
  input  gocd_pkg::rate_t   rate_i,
  output gocd_pkg::rate_t   out_o
);
  import gocd_pkg::*;

  logic signed [SUM_W-1:0]  sum_q, sum_d, sum_next, sum_shift;
  logic [PEAK_W-1:0]        peak_q, peak_d, rate_mag;
  rate_t                    offset_q, offset_d;
  logic [RATE_W-1:0]        rate_neg, diff_mag;
  logic signed [RATE_W:0]   diff;
  rate_t                    diff_sat;

  always_comb begin
    sum_next  = sum_q + {{(SUM_W-RATE_W){rate_i[RATE_W-1]}}, rate_i};
    sum_shift = sum_next >>> CAL_SAMPLES_LOG2;

    // |most negative| clips to the largest 15-bit value
    rate_neg = RATE_W'(-rate_i);
    if (rate_i[RATE_W-1] && (rate_i[RATE_W-2:0] == '0)) begin
      rate_mag = '1;
    end else if (rate_i[RATE_W-1]) begin
      rate_mag = rate_neg[PEAK_W-1:0];
    end else begin
      rate_mag = rate_i[PEAK_W-1:0];
    end

    diff = {rate_i[RATE_W-1], rate_i} - {offset_q[RATE_W-1], offset_q};
    if (diff[RATE_W] != diff[RATE_W-1]) begin
      diff_sat = diff[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end else begin
      diff_sat = diff[RATE_W-1:0];
    end
    diff_mag = diff_sat[RATE_W-1] ? RATE_W'(-diff_sat) : diff_sat;
    out_o = (diff_mag < {1'b0, peak_q}) ? '0 : diff_sat;

    sum_d    = sum_q;
    peak_d   = peak_q;
    offset_d = offset_q;
    if (ctl_i.clear) begin
      sum_d  = '0;
      peak_d = '0;
    end else if (ctl_i.accum) begin
      sum_d = sum_next;
      if (rate_mag > peak_q) begin
        peak_d = rate_mag;
      end
      if (ctl_i.load) begin
        offset_d = sum_shift[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      peak_q   <= '0;
      offset_q <= '0;
    end else begin
      sum_q    <= sum_d;
      peak_q   <= peak_d;
      offset_q <= offset_d;
    end
  end

endmodule

### rtl/gocd_merge.sv
module gocd_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gocd_pkg::rate_t    lane_x_i,
  input  gocd_pkg::rate_t    lane_y_i,
  input  gocd_pkg::rate_t    lane_z_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gocd_pkg::out_res_t out_res_o
);
  import gocd_pkg::*;

  out_res_t res_new;
  out_res_t out_q, out_d, skid_q, skid_d;
  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic     pop;

  always_comb begin
    res_new     = '{out_x: lane_x_i, out_y: lane_y_i, out_z: lane_z_i};
    pop         = out_valid_q && !out_stall_i;
    out_d       = out_q;
    skid_d      = skid_q;
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res_new;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_new;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a request while output is empty");

  a_stalled_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && out_stall_i && !skid_valid_q) |=> skid_valid_q)
    else $error("request lost under output stall");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_stall_i) |=> (!skid_valid_q && out_valid_q))
    else $error("skid did not drain into output");

endmodule

### rtl/gyro_offset_calibration_deadband.sv
// Channel | Valid      | Stall      | Payload
// in      | in_valid_i | in_stall_o | in_req_i  (operation, rate_x/y/z)
// out     | out_valid_o| out_stall_i| out_res_o (out_x/y/z)
// One request per cycle unless in_stall_o is high; each result is registered in the output or skid register.
// Three axis lanes work in parallel, each one add/compare/subtract deep.
// Calibration takes 2^CAL_SAMPLES_LOG2 samples and gives no results.
// Reset: calibration active, sums/peaks/offsets zero.
// in_stall_o rises only when both output and skid registers hold results.
module gyro_offset_calibration_deadband (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gocd_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gocd_pkg::out_res_t out_res_o
);
  import gocd_pkg::*;

  logic             accept, restart, push, full;
  logic             calibrating_q, calibrating_d;
  logic [CNT_W-1:0] count_q, count_d;
  lane_ctl_t        ctl;
  rate_t            lane_x, lane_y, lane_z;

  always_comb begin
    accept  = in_valid_i && !in_stall_o;
    restart = accept && (op_e'(in_req_i.operation) == OP_RESTART);
    push    = accept && !restart && !calibrating_q;

    ctl.clear = restart;
    ctl.accum = accept && !restart && calibrating_q;
    ctl.load  = ctl.accum && (count_q == CAL_SAMPLES - CNT_W'(1));

    count_d       = count_q;
    calibrating_d = calibrating_q;
    if (restart) begin
      count_d       = '0;
      calibrating_d = 1'b1;
    end else if (ctl.accum) begin
      count_d = count_q + CNT_W'(1);
      if (ctl.load) begin
        calibrating_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      calibrating_q <= 1'b1;
    end else begin
      count_q       <= count_d;
      calibrating_q <= calibrating_d;
    end
  end

  gocd_lane u_lane_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .rate_i(in_req_i.rate_x),
    .out_o (lane_x)
  );

  gocd_lane u_lane_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .rate_i(in_req_i.rate_y),
    .out_o (lane_y)
  );

  gocd_lane u_lane_z (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .rate_i(in_req_i.rate_z),
    .out_o (lane_z)
  );

  gocd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .lane_x_i   (lane_x),
    .lane_y_i   (lane_y),
    .lane_z_i   (lane_z),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  assign in_stall_o = full;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calibrating_q |-> (count_q < CAL_SAMPLES))
    else $error("calibration count overran");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !calibrating_q |-> (count_q == CAL_SAMPLES))
    else $error("calibration ended early");

  a_restart_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (calibrating_q && (count_q == '0)))
    else $error("restart did not reopen calibration");

  a_no_result_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calibrating_q |-> !push)
    else $error("result produced during calibration");

endmodule

### test/tb_top.sv
module tb_top;
  import gocd_pkg::*;

  typedef struct {
    op_e         op;
    int          x;
    int          y;
    int          z;
    int unsigned reps;
    bit          typed;
    int          ex;
    int          ey;
    int          ez;
  } plan_row_t;

  localparam int unsigned RANDOM_REQS = 850;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_res_t out_res_o;

  // typed-in expectation that travels with the request on the wire
  bit       req_typed = 1'b0;
  out_res_t req_typed_res = '0;

  // model of the calibration and correction state
  logic signed [SUM_W-1:0] cal_sum [3];
  logic [PEAK_W-1:0]       cal_peak [3];
  rate_t                   cal_offset [3];
  int unsigned             cal_count;
  bit                      cal_active;

  // stimulus shaping for the calibration phase
  int bias [3];
  int amp [3];

  out_res_t    corrected_q [$];
  int unsigned n_miss = 0;
  int unsigned n_checked = 0;
  int unsigned n_reqs = 0;
  int unsigned n_restarts = 0;
  int unsigned n_cals = 0;
  int unsigned n_zeroed = 0;
  int unsigned n_clipped = 0;
  int unsigned burst_left = 0;

  plan_row_t plan [21] = '{
    '{OP_RESTART, 32767, -32768, -1, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 128, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, -32768, 32767, 0, 1, 1'b1, -32768, 32767, 0},
    '{OP_SAMPLE, 32767, -32768, -1, 1, 1'b1, 32767, -32768, -1},
    '{OP_SAMPLE, 1, -1, 21845, 1, 1'b1, 1, -1, 21845},
    '{OP_RESTART, -32768, 32767, 0, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, 100, -100, -32768, 128, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, 300, -300, 32767, 1, 1'b1, 200, -200, 32767},
    '{OP_SAMPLE, 150, -150, -32768, 1, 1'b1, 0, 0, 0},
    '{OP_SAMPLE, -32768, 32767, 0, 1, 1'b1, -32768, 32767, 32767},
    '{OP_SAMPLE, 200, 0, -1, 1, 1'b1, 100, 100, 32767},
    '{OP_SAMPLE, 199, -199, -32768, 1, 1'b1, 0, 0, 0},
    '{OP_SAMPLE, 0, -200, 32767, 1, 1'b1, -100, -100, 32767},
    '{OP_RESTART, 0, 0, 0, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, 1000, 1000, 1000, 50, 1'b0, 0, 0, 0},
    '{OP_RESTART, 1, 1, 1, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, -1, -2, -3, 127, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, -2, -3, -4, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, 0, 0, 0, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, -4, -6, -8, 1, 1'b0, 0, 0, 0},
    '{OP_SAMPLE, -3, -5, -7, 1, 1'b0, 0, 0, 0}
  };

  gyro_offset_calibration_deadband u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic rate_t clamp16(int v);
    if (v > 32767) begin
      return rate_t'(32767);
    end
    if (v < -32768) begin
      return rate_t'(-32768);
    end
    return rate_t'(v);
  endfunction

  task automatic restart_calibration();
    for (int i = 0; i < 3; i++) begin
      cal_sum[i] = '0;
      cal_peak[i] = '0;
    end
    cal_count = 0;
    cal_active = 1'b1;
  endtask

  task automatic predict_correction(input in_req_t r, output bit fires, output out_res_t res);
    rate_t s [3];
    rate_t o [3];
    int    v;
    int    m;
    int    d;
    fires = 1'b0;
    res = '0;
    if (r.operation == OP_RESTART) begin
      restart_calibration();
      return;
    end
    s[0] = r.rate_x;
    s[1] = r.rate_y;
    s[2] = r.rate_z;
    if (cal_active) begin
      for (int i = 0; i < 3; i++) begin
        v = int'(s[i]);
        m = (v < 0) ? -v : v;
        if (m > 32767) begin
          m = 32767;
        end
        cal_sum[i] = cal_sum[i] + s[i];
        if (m > cal_peak[i]) begin
          cal_peak[i] = PEAK_W'(m);
        end
      end
      cal_count++;
      if (cal_count >= (1 << CAL_SAMPLES_LOG2)) begin
        // arithmetic shift gives the floor of the mean, negative sums too
        for (int i = 0; i < 3; i++) begin
          cal_offset[i] = rate_t'(cal_sum[i] >>> CAL_SAMPLES_LOG2);
        end
        cal_active = 1'b0;
        n_cals++;
      end
      return;
    end
    for (int i = 0; i < 3; i++) begin
      d = int'(s[i]) - int'(cal_offset[i]);
      if (d > 32767 || d < -32768) begin
        n_clipped++;
      end
      o[i] = clamp16(d);
      d = int'(o[i]);
      m = (d < 0) ? -d : d;
      if (m < int'(cal_peak[i])) begin
        o[i] = '0;
        n_zeroed++;
      end
    end
    res.out_x = o[0];
    res.out_y = o[1];
    res.out_z = o[2];
    fires = 1'b1;
  endtask

  function automatic rate_t pick_rate(int i);
    int k;
    int v;
    k = $urandom_range(0, 15);
    if (cal_active) begin
      if (k == 0) begin
        v = int'(rate_t'($urandom));
      end else begin
        v = bias[i] + span(-amp[i], amp[i]);
      end
    end else if (k < 6) begin
      v = int'(rate_t'($urandom));
    end else if (k < 12) begin
      // straddle the deadband edge on either side of the offset
      v = int'(cal_offset[i]) + (k[0] ? int'(cal_peak[i]) : -int'(cal_peak[i])) + span(-2, 2);
    end else if (k < 14) begin
      v = int'(cal_offset[i]) + span(-3, 3);
    end else begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return clamp16(v);
  endfunction

  task automatic report_miss(input string msg);
    n_miss++;
    if (n_miss <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic send_request(input in_req_t r, input bit typed, input out_res_t t);
    in_valid_i <= 1'b1;
    in_req_i <= r;
    req_typed <= typed;
    req_typed_res <= t;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  always @(posedge clk_i) begin
    bit       fires;
    out_res_t want;
    out_res_t got;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o === 1'b0) begin
        n_reqs++;
        if (in_req_i.operation == OP_RESTART) begin
          n_restarts++;
        end
        predict_correction(in_req_i, fires, want);
        if (fires) begin
          corrected_q.push_back(req_typed ? req_typed_res : want);
        end
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        got = out_res_o;
        if (corrected_q.size() == 0) begin
          report_miss($sformatf("unexpected result x=%0d y=%0d z=%0d",
                                $signed(got.out_x), $signed(got.out_y), $signed(got.out_z)));
        end else begin
          want = corrected_q.pop_front();
          n_checked++;
          if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
              got.out_z !== want.out_z) begin
            report_miss($sformatf("result %0d expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                  n_checked, $signed(want.out_x), $signed(want.out_y),
                                  $signed(want.out_z), $signed(got.out_x),
                                  $signed(got.out_y), $signed(got.out_z)));
          end
        end
      end
    end
  end

  // receiver: one long hold-off as soon as results flow, then shifting patterns
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned tick;
    bit          hold;
    do @(posedge clk_i); while (out_valid_o !== 1'b1);
    @(negedge clk_i);
    out_stall_i <= 1'b1;
    repeat (64) @(negedge clk_i);
    tick = 0;
    forever begin
      mode = $urandom_range(0, 5);
      seg = (mode == 4) ? $urandom_range(30, 120) : $urandom_range(10, 150);
      repeat (seg) begin
        case (mode)
          0: hold = 1'b0;
          1: hold = ($urandom_range(0, 2) == 0);
          2: hold = tick[0];
          3: hold = ($urandom_range(0, 3) != 0);
          4: hold = 1'b1;
          default: hold = $urandom_range(0, 1);
        endcase
        out_stall_i <= hold;
        tick++;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_req_t  req;
    out_res_t typed_res;
    restart_calibration();
    for (int i = 0; i < 3; i++) begin
      cal_offset[i] = '0;
      bias[i] = 0;
      amp[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < $size(plan); r++) begin
      req.operation = plan[r].op;
      req.rate_x = rate_t'(plan[r].x);
      req.rate_y = rate_t'(plan[r].y);
      req.rate_z = rate_t'(plan[r].z);
      typed_res.out_x = rate_t'(plan[r].ex);
      typed_res.out_y = rate_t'(plan[r].ey);
      typed_res.out_z = rate_t'(plan[r].ez);
      repeat (plan[r].reps) send_request(req, plan[r].typed, typed_res);
    end

    // restarts land anywhere, so some calibrations are cut short
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 0 || $urandom_range(0, 349) == 0) begin
        for (int i = 0; i < 3; i++) begin
          bias[i] = ($urandom_range(0, 4) == 0) ? int'(rate_t'($urandom)) : span(-3000, 3000);
          case ($urandom_range(0, 3))
            0: amp[i] = 0;
            1: amp[i] = span(1, 8);
            2: amp[i] = span(1, 300);
            default: amp[i] = span(1, 3000);
          endcase
        end
        req.operation = OP_RESTART;
        req.rate_x = rate_t'($urandom);
        req.rate_y = rate_t'($urandom);
        req.rate_z = rate_t'($urandom);
      end else begin
        req.operation = OP_SAMPLE;
        req.rate_x = pick_rate(0);
        req.rate_y = pick_rate(1);
        req.rate_z = pick_rate(2);
      end
      send_request(req, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (corrected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Covered %0d requests (%0d restarts, %0d calibrations finished), %0d results checked.",
             n_reqs, n_restarts, n_cals, n_checked);
    $display("Axes zeroed in deadband: %0d, axes clipped at full scale: %0d, mismatches: %0d.",
             n_zeroed, n_clipped, n_miss);
    if (n_miss == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
